FILE: rtl/ans_pkg.sv
// Shared types, constants and helpers for the affine nearest neighbor sampler.
package ans_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int PIXEL_BITS     = 8;

   localparam int COL_BITS  = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int ROW_BITS  = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int ADDR_BITS = (MAX_SRC_WIDTH * MAX_SRC_HEIGHT > 1)
                              ? $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT) : 1;

   localparam int COORD_BITS     = 12;
   localparam int COORD_CMP_BITS = COORD_BITS + 1;
   localparam int PIXEL_IO_BITS  = 8;
   localparam int COEF_BITS      = 32;
   localparam int CENTER_BITS    = COORD_BITS + 2;
   localparam int PROD_BITS      = COEF_BITS + CENTER_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int FRAC_BITS      = 17;
   localparam int SRC_BITS       = ACC_BITS - FRAC_BITS;
   localparam int EXT_DIM_BITS   = 9;
   localparam int EXT_BITS       = 2 * EXT_DIM_BITS;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_IDX_BITS   = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef logic [ADDR_BITS-1:0]             addr_type;
   typedef logic [PIXEL_BITS-1:0]            pixel_type;
   typedef logic [PIXEL_IO_BITS-1:0]         pixel_io_type;
   typedef logic [COORD_CMP_BITS-1:0]        coord_cmp_type;
   typedef logic signed [CENTER_BITS-1:0]    center_type;
   typedef logic signed [PROD_BITS-1:0]      prod_type;
   typedef logic signed [ACC_BITS-1:0]       acc_type;
   typedef logic [SRC_BITS-1:0]              src_type;
   typedef logic [CSR_DATA_BITS-1:0]         csr_data_type;

   typedef struct packed {
      logic                    op;
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic [PIXEL_IO_BITS-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_IO_BITS-1:0] pixel_out;
      logic                     in_bounds;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coef_a;
      logic signed [COEF_BITS-1:0] coef_b;
      logic signed [COEF_BITS-1:0] coef_c;
      logic signed [COEF_BITS-1:0] coef_d;
      logic signed [COEF_BITS-1:0] offset_x;
      logic signed [COEF_BITS-1:0] offset_y;
      logic [PIXEL_IO_BITS-1:0]    fill_value;
      logic [EXT_BITS-1:0]         source_extent;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      logic     in_src;
      addr_type addr;
   } lookup_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_COEF_A        = 3'd0,
      REG_COEF_B        = 3'd1,
      REG_COEF_C        = 3'd2,
      REG_COEF_D        = 3'd3,
      REG_OFFSET_X      = 3'd4,
      REG_OFFSET_Y      = 3'd5,
      REG_FILL_VALUE    = 3'd6,
      REG_SOURCE_EXTENT = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_LOAD
   } state_type;

   function automatic addr_type make_addr(input logic [ROW_BITS-1:0] row,
                                          input logic [COL_BITS-1:0] col);
      make_addr = addr_type'(row) * addr_type'(MAX_SRC_WIDTH) + addr_type'(col);
   endfunction

endpackage

FILE: rtl/ans_csr.sv
// Configuration register file with an APB-style access port.
module ans_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ans_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ans_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ans_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output ans_pkg::cfg_type                    cfg
);

   ans_pkg::cfg_type       cfg_ff;
   ans_pkg::cfg_type       cfg_in;
   ans_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign reg_idx    = ans_pkg::reg_index_type'(csr_paddr[ans_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            ans_pkg::REG_COEF_A:        cfg_in.coef_a   = csr_pwdata;
            ans_pkg::REG_COEF_B:        cfg_in.coef_b   = csr_pwdata;
            ans_pkg::REG_COEF_C:        cfg_in.coef_c   = csr_pwdata;
            ans_pkg::REG_COEF_D:        cfg_in.coef_d   = csr_pwdata;
            ans_pkg::REG_OFFSET_X:      cfg_in.offset_x = csr_pwdata;
            ans_pkg::REG_OFFSET_Y:      cfg_in.offset_y = csr_pwdata;
            ans_pkg::REG_FILL_VALUE:
               cfg_in.fill_value = csr_pwdata[ans_pkg::PIXEL_IO_BITS-1:0];
            ans_pkg::REG_SOURCE_EXTENT:
               cfg_in.source_extent = csr_pwdata[ans_pkg::EXT_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ans_pkg::REG_COEF_A:        csr_prdata = cfg_ff.coef_a;
         ans_pkg::REG_COEF_B:        csr_prdata = cfg_ff.coef_b;
         ans_pkg::REG_COEF_C:        csr_prdata = cfg_ff.coef_c;
         ans_pkg::REG_COEF_D:        csr_prdata = cfg_ff.coef_d;
         ans_pkg::REG_OFFSET_X:      csr_prdata = cfg_ff.offset_x;
         ans_pkg::REG_OFFSET_Y:      csr_prdata = cfg_ff.offset_y;
         ans_pkg::REG_FILL_VALUE:
            csr_prdata = ans_pkg::csr_data_type'(cfg_ff.fill_value);
         ans_pkg::REG_SOURCE_EXTENT:
            csr_prdata = ans_pkg::csr_data_type'(cfg_ff.source_extent);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a        <= 32'sd65536;
         cfg_ff.coef_b        <= '0;
         cfg_ff.coef_c        <= '0;
         cfg_ff.coef_d        <= 32'sd65536;
         cfg_ff.offset_x      <= '0;
         cfg_ff.offset_y      <= '0;
         cfg_ff.fill_value    <= '0;
         cfg_ff.source_extent <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/ans_map.sv
// Three-stage coordinate mapper: products, Q.17 sums, floor and bounds check.
module ans_map (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ans_pkg::COORD_BITS-1:0]    x,
   input  logic [ans_pkg::COORD_BITS-1:0]    y,
   input  ans_pkg::cfg_type                  cfg,
   output ans_pkg::lookup_type               lookup
);

   ans_pkg::center_type cx;
   ans_pkg::center_type cy;

   logic              s1_valid_ff;
   ans_pkg::prod_type prod_ax_ff, prod_by_ff, prod_cx_ff, prod_dy_ff;
   ans_pkg::prod_type prod_ax_in, prod_by_in, prod_cx_in, prod_dy_in;

   logic              s2_valid_ff;
   ans_pkg::acc_type  acc_x_ff, acc_y_ff;
   ans_pkg::acc_type  acc_x_in, acc_y_in;

   logic              s3_valid_ff;
   logic              inside_ff;
   ans_pkg::addr_type addr_ff;
   logic              inside_in;
   ans_pkg::addr_type addr_in;

   ans_pkg::src_type  sx, sy;
   ans_pkg::src_type  ext_w, ext_h;
   logic              inside_x, inside_y;

   assign cx = ans_pkg::center_type'({1'b0, x, 1'b1});
   assign cy = ans_pkg::center_type'({1'b0, y, 1'b1});

   assign prod_ax_in = ans_pkg::prod_type'(cfg.coef_a) * ans_pkg::prod_type'(cx);
   assign prod_by_in = ans_pkg::prod_type'(cfg.coef_b) * ans_pkg::prod_type'(cy);
   assign prod_cx_in = ans_pkg::prod_type'(cfg.coef_c) * ans_pkg::prod_type'(cx);
   assign prod_dy_in = ans_pkg::prod_type'(cfg.coef_d) * ans_pkg::prod_type'(cy);

   assign acc_x_in = ans_pkg::acc_type'(prod_ax_ff) + ans_pkg::acc_type'(prod_by_ff)
                   + ans_pkg::acc_type'(signed'({cfg.offset_x, 1'b0}));
   assign acc_y_in = ans_pkg::acc_type'(prod_cx_ff) + ans_pkg::acc_type'(prod_dy_ff)
                   + ans_pkg::acc_type'(signed'({cfg.offset_y, 1'b0}));

   // floor toward minus infinity
   assign sx = acc_x_ff[ans_pkg::ACC_BITS-1:ans_pkg::FRAC_BITS];
   assign sy = acc_y_ff[ans_pkg::ACC_BITS-1:ans_pkg::FRAC_BITS];

   assign ext_w = ans_pkg::src_type'(cfg.source_extent[ans_pkg::EXT_DIM_BITS-1:0]);
   assign ext_h = ans_pkg::src_type'(
                  cfg.source_extent[ans_pkg::EXT_BITS-1:ans_pkg::EXT_DIM_BITS]);

   assign inside_x = !sx[ans_pkg::SRC_BITS-1] && (sx < ext_w)
                   && (sx < ans_pkg::src_type'(ans_pkg::MAX_SRC_WIDTH));
   assign inside_y = !sy[ans_pkg::SRC_BITS-1] && (sy < ext_h)
                   && (sy < ans_pkg::src_type'(ans_pkg::MAX_SRC_HEIGHT));
   assign inside_in = inside_x && inside_y;
   assign addr_in   = ans_pkg::make_addr(sy[ans_pkg::ROW_BITS-1:0],
                                         sx[ans_pkg::COL_BITS-1:0]);

   assign lookup.valid  = s3_valid_ff;
   assign lookup.in_src = inside_ff;
   assign lookup.addr   = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ax_ff <= prod_ax_in;
      prod_by_ff <= prod_by_in;
      prod_cx_ff <= prod_cx_in;
      prod_dy_ff <= prod_dy_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      inside_ff  <= inside_in;
      addr_ff    <= addr_in;
   end

endmodule

FILE: rtl/ans_image.sv
// Source image store: one write port, one registered read port.
module ans_image (
   input  logic                clock,
   input  logic                wr_en,
   input  ans_pkg::addr_type   wr_addr,
   input  ans_pkg::pixel_type  wr_data,
   input  logic                rd_en,
   input  ans_pkg::addr_type   rd_addr,
   output ans_pkg::pixel_type  rd_data
);

   ans_pkg::pixel_type mem [ans_pkg::MAX_SRC_WIDTH * ans_pkg::MAX_SRC_HEIGHT];
   ans_pkg::pixel_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/affine_nearest_neighbor_sampler.sv
// Top level: item sequencer, image store, coordinate mapper and register file.
//
// A write item stores one source pixel, and the block can take the next item
// in the following cycle. A read item's result is loaded into the output
// register in order: the accepting edge loads the coordinate mapper's
// products, and later edges take the sums, the floor and bounds check, the
// image store's registered read and the result load. The block works on one
// read item at a time and stalls its input until that result is loaded. A
// finished result waiting in the output register does not hold off the next
// item, but the next read's result waits until the receiver takes the
// previous one. The image store powers up with undefined contents and needs
// no clearing pass.
module affine_nearest_neighbor_sampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ans_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ans_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ans_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ans_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ans_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   ans_pkg::cfg_type    cfg;
   ans_pkg::lookup_type lookup;
   ans_pkg::state_type  state_ff, state_in;
   ans_pkg::pixel_type  rd_data;

   logic              accept;
   logic              start;
   logic              wr_en;
   ans_pkg::addr_type wr_addr;
   logic              can_load;
   logic              load;
   logic              inside_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   ans_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   ans_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ans_map u_map (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .x      (req_data.x),
      .y      (req_data.y),
      .cfg    (cfg),
      .lookup (lookup)
   );

   ans_image u_image (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ans_pkg::pixel_type'(req_data.pixel_in)),
      .rd_en   (lookup.valid),
      .rd_addr (lookup.addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ans_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_data.op == ans_pkg::OP_READ);

   // drop writes outside the store
   assign wr_en = accept && (req_data.op == ans_pkg::OP_WRITE)
                && (ans_pkg::coord_cmp_type'(req_data.x)
                    < ans_pkg::coord_cmp_type'(ans_pkg::MAX_SRC_WIDTH))
                && (ans_pkg::coord_cmp_type'(req_data.y)
                    < ans_pkg::coord_cmp_type'(ans_pkg::MAX_SRC_HEIGHT));
   assign wr_addr = ans_pkg::make_addr(req_data.y[ans_pkg::ROW_BITS-1:0],
                                       req_data.x[ans_pkg::COL_BITS-1:0]);

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         ans_pkg::ST_IDLE: begin
            if (start) begin
               state_in = ans_pkg::ST_MAP;
            end
         end
         ans_pkg::ST_MAP: begin
            if (lookup.valid) begin
               state_in = ans_pkg::ST_LOAD;
            end
         end
         ans_pkg::ST_LOAD: begin
            if (can_load) begin
               load     = 1'b1;
               state_in = ans_pkg::ST_IDLE;
            end
         end
         default: state_in = ans_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ans_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the mapper's verdict until the stored pixel arrives
   always_ff @(posedge clock) begin
      if (lookup.valid) begin
         inside_ff <= lookup.in_src;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_data_in.in_bounds = inside_ff;
         rsp_data_in.pixel_out = inside_ff ? ans_pkg::pixel_io_type'(rd_data)
                                           : cfg.fill_value;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
